FILE: src/mcaw_pkg.sv
// shared types and constants for the multi-channel activity watchdog
// no dependencies; imported by every module of the block
`default_nettype none

package mcaw_pkg;

   localparam int CHANNELS_DEF   = 6;
   localparam int COUNT_BITS_DEF = 16;
   localparam int MODE_BITS      = 2;
   localparam int CHAN_BITS      = 3;
   localparam int MIN_BITS       = 16;
   localparam int FAIL_BITS      = 3;

   localparam logic [MIN_BITS-1:0]  MIN_MESSAGES_RESET = 16'd5;
   localparam logic [FAIL_BITS-1:0] HEALTHY_CODE       = 3'd6;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_COUNT       = 2'd0,
      MODE_ENABLE      = 2'd1,
      MODE_DISABLE_ALL = 2'd2,
      MODE_CHECK       = 2'd3
   } mode_type;

   // outcome of one window check
   typedef struct packed {
      logic                 all_healthy;
      logic [FAIL_BITS-1:0] failed_channel;
   } scan_type;

endpackage

`default_nettype wire

FILE: src/multi_channel_activity_watchdog.sv
// top level of the multi-channel activity watchdog: input register, threshold csr
// depends on mcaw_pkg, mcaw_chan_bank, mcaw_rsp_reg
//
//   port group   dir  handshake            contents
//   req_*        in   req_valid/req_stall  mode, channel
//   rsp_*        out  rsp_valid/rsp_stall  failed_channel, all_healthy
//   csr_*        in   csr_write_enable     min_messages threshold
//
// one word per cycle unless a window check waits on a stalled result: a word
// is taken into the input register, then the channel bank updates its state and,
// for a window check, the result register loads and drives the output
// reset (synchronous) clears enables, counts, last counts, threshold to 5
// a stalled result holds the next window check in the input register, which
// then stalls the input; other words pass while a result waits
`default_nettype none

module multi_channel_activity_watchdog
   import mcaw_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [MODE_BITS-1:0] req_mode,
   input  wire logic [CHAN_BITS-1:0] req_channel,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [FAIL_BITS-1:0]      rsp_failed_channel,
   output logic                      rsp_all_healthy,
   input  wire logic                 csr_write_enable,
   input  wire logic [MIN_BITS-1:0]  csr_write_data
);

   // threshold register
   logic [MIN_BITS-1:0] min_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   mode_type             mode_ff;
   logic [CHAN_BITS-1:0] channel_ff;

   logic     accept;
   logic     advance;
   logic     is_check;
   logic     rsp_free;
   scan_type scan;

   assign is_check  = (mode_ff == MODE_CHECK);
   // only a check needs room in the result register
   assign advance   = in_valid_ff && (!is_check || rsp_free);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         min_ff      <= MIN_MESSAGES_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write_enable) begin
            min_ff <= csr_write_data;
         end
      end
      if (accept) begin
         mode_ff    <= mode_type'(req_mode);
         channel_ff <= req_channel;
      end
   end

   mcaw_chan_bank #(
      .CHANNELS   (CHANNELS),
      .COUNT_BITS (COUNT_BITS)
   ) u_bank (
      .clock        (clock),
      .reset        (reset),
      .process      (advance),
      .mode         (mode_ff),
      .channel      (channel_ff),
      .min_messages (min_ff),
      .scan         (scan)
   );

   mcaw_rsp_reg u_rsp (
      .clock              (clock),
      .reset              (reset),
      .load               (advance && is_check),
      .scan               (scan),
      .free               (rsp_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_failed_channel (rsp_failed_channel),
      .rsp_all_healthy    (rsp_all_healthy)
   );

   // the input side only waits behind a window check
   a_stall_only_on_check: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && is_check))
      else $error("input stalled behind a non-check word");

   // a new result only follows a window check leaving the input register
   a_result_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff && is_check))
      else $error("result appeared without a window check");

   // healthy results carry the healthy code
   a_healthy_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_all_healthy) |-> (rsp_failed_channel == HEALTHY_CODE))
      else $error("healthy result with a channel index");

   // nothing pending right after reset
   a_reset_clean: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: src/mcaw_chan_bank.sv
// per-channel state: enables, message counters, last window counts, window scan
// depends on mcaw_pkg
`default_nettype none

module mcaw_chan_bank
   import mcaw_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 process,
   input  wire mode_type             mode,
   input  wire logic [CHAN_BITS-1:0] channel,
   input  wire logic [MIN_BITS-1:0]  min_messages,
   output scan_type                  scan
);

   localparam int CMP_BITS = (COUNT_BITS > MIN_BITS) ? COUNT_BITS : MIN_BITS;

   logic [CHANNELS-1:0]   enabled_ff, enabled_in;
   logic [COUNT_BITS-1:0] count_ff [CHANNELS];
   logic [COUNT_BITS-1:0] count_in [CHANNELS];
   logic [COUNT_BITS-1:0] last_ff  [CHANNELS];
   logic [COUNT_BITS-1:0] last_in  [CHANNELS];

   logic [CHANNELS-1:0] fail_hit;
   logic [CHANNELS-1:0] before_fail;

   // fail flags are independent compares, before_fail is a one-bit prefix
   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         fail_hit[k] = enabled_ff[k] &&
                       (CMP_BITS'(count_ff[k]) <= CMP_BITS'(min_messages));
      end
      before_fail[0] = 1'b1;
      for (int k = 1; k < CHANNELS; k++) begin
         before_fail[k] = before_fail[k-1] && !fail_hit[k-1];
      end
   end

   // lowest failing channel wins
   always_comb begin
      scan.all_healthy    = 1'b1;
      scan.failed_channel = HEALTHY_CODE;
      for (int k = CHANNELS - 1; k >= 0; k--) begin
         if (fail_hit[k]) begin
            scan.all_healthy    = 1'b0;
            scan.failed_channel = FAIL_BITS'(k);
         end
      end
   end

   always_comb begin
      enabled_in = enabled_ff;
      for (int k = 0; k < CHANNELS; k++) begin
         count_in[k] = count_ff[k];
         last_in[k]  = last_ff[k];
      end
      if (process) begin
         case (mode)
            MODE_COUNT: begin
               for (int k = 0; k < CHANNELS; k++) begin
                  if (int'(channel) == k && count_ff[k] != {COUNT_BITS{1'b1}}) begin
                     count_in[k] = count_ff[k] + COUNT_BITS'(1);
                  end
               end
            end
            MODE_ENABLE: begin
               for (int k = 0; k < CHANNELS; k++) begin
                  if (int'(channel) == k) begin
                     enabled_in[k] = 1'b1;
                     count_in[k]   = '0;
                  end
               end
            end
            MODE_DISABLE_ALL: begin
               enabled_in = '0;
               for (int k = 0; k < CHANNELS; k++) begin
                  count_in[k] = '0;
               end
            end
            MODE_CHECK: begin
               for (int k = 0; k < CHANNELS; k++) begin
                  if (enabled_ff[k] && before_fail[k]) begin
                     last_in[k] = count_ff[k];
                     if (!fail_hit[k]) begin
                        count_in[k] = '0;
                     end
                  end
               end
            end
            default: begin
               enabled_in = enabled_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= '0;
         for (int k = 0; k < CHANNELS; k++) begin
            count_ff[k] <= '0;
            last_ff[k]  <= '0;
         end
      end else begin
         enabled_ff <= enabled_in;
         for (int k = 0; k < CHANNELS; k++) begin
            count_ff[k] <= count_in[k];
            last_ff[k]  <= last_in[k];
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/mcaw_rsp_reg.sv
// result register for window check outcomes, valid/stall on the output side
// depends on mcaw_pkg
`default_nettype none

module mcaw_rsp_reg
   import mcaw_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire scan_type             scan,
   output logic                      free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [FAIL_BITS-1:0]      rsp_failed_channel,
   output logic                      rsp_all_healthy
);

   logic     valid_ff, valid_in;
   scan_type data_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= scan;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_failed_channel = data_ff.failed_channel;
   assign rsp_all_healthy    = data_ff.all_healthy;

endmodule

`default_nettype wire
